### src/ivpd_pkg.sv
// ----------------------------------------------------------------------------
// ivpd_pkg
// Shared types, constants and the per-axis microprogram of the drift filter.
// ----------------------------------------------------------------------------
package ivpd_pkg;

	localparam int unsigned AXES      = 3;
	localparam int unsigned STEPS     = 15;	// microprogram steps per axis
	localparam int unsigned ACCEL_W   = 24;
	localparam int unsigned OUT_W     = 32;
	localparam int unsigned STATE_W   = 48;
	localparam int unsigned MUL_W     = 25;	// signed operand width of the shared multiplier
	localparam int unsigned PROD_W    = 2 * MUL_W;
	localparam int unsigned LOW_W     = 25;	// rounded low partial product
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;
	localparam int unsigned DT_W      = 24;
	localparam int unsigned GAIN_W    = 16;

	localparam logic [DT_W-1:0]   DT_RESET   = 24'd65536;
	localparam logic [GAIN_W-1:0] K_RESET    = 16'd65376;
	localparam logic [GAIN_W-1:0] OG_RESET   = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 2'd2;

	typedef logic [3:0] step_t;
	typedef logic [1:0] axis_t;

	// multiplier A operand
	typedef enum logic [2:0] {
		A_ACCEL,
		A_W_HI,
		A_W_LO,
		A_VEL_HI,
		A_VEL_LO,
		A_POS_HI,
		A_POS_LO
	} asel_t;

	// multiplier B operand
	typedef enum logic [1:0] {
		B_DT,
		B_K,
		B_OG
	} bsel_t;

	// what the datapath does with last cycle's product
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_INC,	// w = sat48(vel + round(a*dt/2^8))
		ACT_LOW16,	// lp = round(lo*k/2^16)
		ACT_FILT_V,	// vel = w = hi*k*2^8 + lp
		ACT_LOW24,	// lp = round(lo*dt/2^24)
		ACT_PINC,	// w = sat48(pos + hi*dt + lp)
		ACT_FILT_P,	// pos = w = hi*k*2^8 + lp
		ACT_LOWG,	// lp = (lo*og + 2^31) >> 24
		ACT_OUT_V,	// vel result = sat32((hi*og + lp) >>> 8)
		ACT_OUT_P
	} act_t;

	typedef struct packed {
		asel_t a_sel;
		bsel_t b_sel;
		act_t  act;
	} uop_t;

	typedef struct packed {
		asel_t a_sel;
		bsel_t b_sel;
		act_t  act;
		axis_t axis;
		logic  capture;
		logic  load_out;
	} dp_cmd_t;

	localparam step_t LAST_STEP = step_t'(STEPS - 1);
	localparam axis_t LAST_AXIS = axis_t'(AXES - 1);

	// Per-axis microprogram. A product issued in one step is consumed by
	// the act of the next step.
	function automatic uop_t step_uop(input step_t step);
		uop_t u;
		u = '{a_sel: A_ACCEL, b_sel: B_DT, act: ACT_NONE};
		unique case (step)
			4'd0:  u = '{a_sel: A_ACCEL,  b_sel: B_DT, act: ACT_NONE};
			4'd1:  u = '{a_sel: A_ACCEL,  b_sel: B_DT, act: ACT_INC};
			4'd2:  u = '{a_sel: A_W_LO,   b_sel: B_K,  act: ACT_NONE};
			4'd3:  u = '{a_sel: A_W_HI,   b_sel: B_K,  act: ACT_LOW16};
			4'd4:  u = '{a_sel: A_ACCEL,  b_sel: B_DT, act: ACT_FILT_V};
			4'd5:  u = '{a_sel: A_W_LO,   b_sel: B_DT, act: ACT_NONE};
			4'd6:  u = '{a_sel: A_W_HI,   b_sel: B_DT, act: ACT_LOW24};
			4'd7:  u = '{a_sel: A_ACCEL,  b_sel: B_DT, act: ACT_PINC};
			4'd8:  u = '{a_sel: A_W_LO,   b_sel: B_K,  act: ACT_NONE};
			4'd9:  u = '{a_sel: A_W_HI,   b_sel: B_K,  act: ACT_LOW16};
			4'd10: u = '{a_sel: A_VEL_LO, b_sel: B_OG, act: ACT_FILT_P};
			4'd11: u = '{a_sel: A_VEL_HI, b_sel: B_OG, act: ACT_LOWG};
			4'd12: u = '{a_sel: A_POS_LO, b_sel: B_OG, act: ACT_OUT_V};
			4'd13: u = '{a_sel: A_POS_HI, b_sel: B_OG, act: ACT_LOWG};
			4'd14: u = '{a_sel: A_ACCEL,  b_sel: B_DT, act: ACT_OUT_P};
			default: u = '{a_sel: A_ACCEL, b_sel: B_DT, act: ACT_NONE};
		endcase
		return u;
	endfunction

endpackage

### src/imu_velocity_position_drift_filter_core.sv
// ----------------------------------------------------------------------------
// imu_velocity_position_drift_filter_core
// Three-axis double integrator with first-order high-pass drift removal.
// ----------------------------------------------------------------------------
// Input channel: one word = accel_x/y/z, signed Q7.16. A word is taken when
// in_valid is high and in_stall is low. in_stall stays high while an item
// is being worked on.
// Output channel: one word per input word: vel_x/y/z and pos_x/y/z, the
// filtered velocity and position times output_gain, rounded and saturated
// to signed 32 bits. Taken when out_valid is high and out_stall is low.
// Config channel: cfg_index selects sample_period (0), hp_gain (1) or
// output_gain (2); cfg_data carries the value. cfg_ready is always high;
// index 3 is ignored. Write only while the block is idle.
// Operation: a word runs 15 microprogram steps per axis on the single
// shared 25x25 multiplier; no new word is taken until all three axes are
// done and the result has moved into the output register.
// The result sits in its own output register, so the next word is taken
// and processed while a stalled result waits; only the final handoff into
// that register waits for the receiver to take the old word.
// Reset: registers return to their defaults, all filter state is cleared,
// no result is pending.
// ----------------------------------------------------------------------------
module imu_velocity_position_drift_filter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input samples
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_x,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_y,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_z,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_x,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_y,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_z,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_x,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_y,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_z,
	// register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ivpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ivpd_pkg::CFG_DAT_W-1:0]        cfg_data
);

	ivpd_pkg::dp_cmd_t cmd;

	// writes are always accepted
	assign cfg_ready = 1'b1;

	// sequencer: step/axis counters, handshakes, output-slot tracking
	ivpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// registers, filter state, shared multiplier, output word
	ivpd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z)
	);

endmodule

### src/ivpd_ctrl.sv
// ----------------------------------------------------------------------------
// ivpd_ctrl
// Sequencer: walks the microprogram over the three axes and owns the handshakes.
// ----------------------------------------------------------------------------
module ivpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ivpd_pkg::dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	ivpd_pkg::step_t       step_q;
	ivpd_pkg::axis_t       axis_q;
	logic                  out_valid_q;
	logic                  slot_free;
	logic                  load;
	ivpd_pkg::uop_t        uop;

	assign slot_free = !out_valid_q || !out_stall;
	assign load      = (state_q == ST_DONE) && slot_free;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign uop       = ivpd_pkg::step_uop(step_q);

	always_comb begin
		cmd = '{a_sel: uop.a_sel, b_sel: uop.b_sel, act: uop.act, axis: axis_q,
			capture: 1'b0, load_out: load};
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		if (state_q != ST_RUN) begin
			cmd.act = ivpd_pkg::ACT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						axis_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == ivpd_pkg::LAST_STEP) begin
						step_q <= '0;
						if (axis_q == ivpd_pkg::LAST_AXIS) begin
							state_q <= ST_DONE;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/ivpd_datapath.sv
// ----------------------------------------------------------------------------
// ivpd_datapath
// Config registers, filter state, one shared 25x25 multiplier and the
// output word register.
// ----------------------------------------------------------------------------
module ivpd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ivpd_pkg::dp_cmd_t                     cmd,
	input  logic                                  cfg_we,
	input  logic [ivpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ivpd_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_x,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_y,
	input  logic signed [ivpd_pkg::ACCEL_W-1:0]   accel_z,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_x,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_y,
	output logic signed [ivpd_pkg::OUT_W-1:0]     vel_z,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_x,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_y,
	output logic signed [ivpd_pkg::OUT_W-1:0]     pos_z
);

	localparam int unsigned PW = ivpd_pkg::PROD_W;
	localparam int unsigned SW = ivpd_pkg::STATE_W;

	function automatic logic signed [SW-1:0] sat48(input logic signed [PW-1:0] v);
		logic signed [SW-1:0] r;
		if (v[PW-1:SW-1] == '0 || v[PW-1:SW-1] == '1) begin
			r = v[SW-1:0];
		end else if (v[PW-1]) begin
			r = {1'b1, {(SW-1){1'b0}}};
		end else begin
			r = {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [ivpd_pkg::OUT_W-1:0] sat32(
		input logic signed [PW-1:0] v);
		logic signed [ivpd_pkg::OUT_W-1:0] r;
		if (v[PW-1:ivpd_pkg::OUT_W-1] == '0 || v[PW-1:ivpd_pkg::OUT_W-1] == '1) begin
			r = v[ivpd_pkg::OUT_W-1:0];
		end else if (v[PW-1]) begin
			r = {1'b1, {(ivpd_pkg::OUT_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ivpd_pkg::OUT_W-1){1'b1}}};
		end
		return r;
	endfunction

	// configuration
	logic [ivpd_pkg::DT_W-1:0]   dt_q;
	logic [ivpd_pkg::GAIN_W-1:0] k_q;
	logic [ivpd_pkg::GAIN_W-1:0] og_q;

	// state and working registers
	logic signed [ivpd_pkg::ACCEL_W-1:0] accel_q  [ivpd_pkg::AXES];
	logic signed [SW-1:0]                vel_q    [ivpd_pkg::AXES];
	logic signed [SW-1:0]                pos_q    [ivpd_pkg::AXES];
	logic signed [ivpd_pkg::OUT_W-1:0]   res_v_q  [ivpd_pkg::AXES];
	logic signed [ivpd_pkg::OUT_W-1:0]   res_p_q  [ivpd_pkg::AXES];
	logic signed [ivpd_pkg::OUT_W-1:0]   outv_q   [ivpd_pkg::AXES];
	logic signed [ivpd_pkg::OUT_W-1:0]   outp_q   [ivpd_pkg::AXES];
	logic signed [SW-1:0]                w_q;
	logic        [ivpd_pkg::LOW_W-1:0]   lp_q;
	logic signed [PW-1:0]                prod_q;

	logic signed [ivpd_pkg::MUL_W-1:0] a_op;
	logic signed [ivpd_pkg::MUL_W-1:0] b_op;
	logic signed [SW-1:0]              vel_cur;
	logic signed [SW-1:0]              pos_cur;
	logic signed [PW-1:0]              lp_ext;
	logic signed [PW-1:0]              inc_sum;
	logic signed [PW-1:0]              pinc_sum;
	logic signed [PW-1:0]              filt_sum;
	logic signed [PW-1:0]              out_sum;
	logic        [40:0]                low16_sum;
	logic        [48:0]                low24_sum;
	logic        [40:0]                lowg_sum;

	assign vel_cur = vel_q[cmd.axis];
	assign pos_cur = pos_q[cmd.axis];
	assign lp_ext  = PW'(signed'({1'b0, lp_q}));

	always_comb begin
		unique case (cmd.a_sel)
			ivpd_pkg::A_ACCEL:  a_op = {accel_q[cmd.axis][ivpd_pkg::ACCEL_W-1],
				accel_q[cmd.axis]};
			ivpd_pkg::A_W_HI:   a_op = {w_q[SW-1], w_q[SW-1:24]};
			ivpd_pkg::A_W_LO:   a_op = {1'b0, w_q[23:0]};
			ivpd_pkg::A_VEL_HI: a_op = {vel_cur[SW-1], vel_cur[SW-1:24]};
			ivpd_pkg::A_VEL_LO: a_op = {1'b0, vel_cur[23:0]};
			ivpd_pkg::A_POS_HI: a_op = {pos_cur[SW-1], pos_cur[SW-1:24]};
			ivpd_pkg::A_POS_LO: a_op = {1'b0, pos_cur[23:0]};
			default:            a_op = '0;
		endcase
		unique case (cmd.b_sel)
			ivpd_pkg::B_DT: b_op = {1'b0, dt_q};
			ivpd_pkg::B_K:  b_op = {9'd0, k_q};
			ivpd_pkg::B_OG: b_op = {9'd0, og_q};
			default:        b_op = '0;
		endcase
	end

	// consumers of last cycle's product
	always_comb begin
		inc_sum   = PW'(signed'(vel_cur)) + ((prod_q + PW'(128)) >>> 8);
		pinc_sum  = PW'(signed'(pos_cur)) + prod_q + lp_ext;
		filt_sum  = (prod_q <<< 8) + lp_ext;
		out_sum   = (prod_q + lp_ext) >>> 8;
		low16_sum = {1'b0, prod_q[39:0]} + 41'd32768;
		low24_sum = {1'b0, prod_q[47:0]} + 49'd8388608;
		lowg_sum  = {1'b0, prod_q[39:0]} + 41'h0_8000_0000;
	end

	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= ivpd_pkg::DT_RESET;
			k_q  <= ivpd_pkg::K_RESET;
			og_q <= ivpd_pkg::OG_RESET;
			for (int i = 0; i < ivpd_pkg::AXES; i++) begin
				vel_q[i] <= '0;
				pos_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ivpd_pkg::REG_SAMPLE_PERIOD: dt_q <= cfg_data;
					ivpd_pkg::REG_HP_GAIN:       k_q  <= cfg_data[ivpd_pkg::GAIN_W-1:0];
					ivpd_pkg::REG_OUTPUT_GAIN:   og_q <= cfg_data[ivpd_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.act == ivpd_pkg::ACT_FILT_V) begin
				vel_q[cmd.axis] <= filt_sum[SW-1:0];
			end
			if (cmd.act == ivpd_pkg::ACT_FILT_P) begin
				pos_q[cmd.axis] <= filt_sum[SW-1:0];
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			accel_q[0] <= accel_x;
			accel_q[1] <= accel_y;
			accel_q[2] <= accel_z;
		end
		unique case (cmd.act)
			ivpd_pkg::ACT_INC:    w_q  <= sat48(inc_sum);
			ivpd_pkg::ACT_LOW16:  lp_q <= low16_sum[40:16];
			ivpd_pkg::ACT_FILT_V: w_q  <= filt_sum[SW-1:0];
			ivpd_pkg::ACT_LOW24:  lp_q <= low24_sum[48:24];
			ivpd_pkg::ACT_PINC:   w_q  <= sat48(pinc_sum);
			ivpd_pkg::ACT_FILT_P: w_q  <= filt_sum[SW-1:0];
			ivpd_pkg::ACT_LOWG:   lp_q <= {8'd0, lowg_sum[40:24]};
			ivpd_pkg::ACT_OUT_V:  res_v_q[cmd.axis] <= sat32(out_sum);
			ivpd_pkg::ACT_OUT_P:  res_p_q[cmd.axis] <= sat32(out_sum);
			default: ;
		endcase
		if (cmd.load_out) begin
			outv_q <= res_v_q;
			outp_q <= res_p_q;
		end
	end

	assign vel_x = outv_q[0];
	assign vel_y = outv_q[1];
	assign vel_z = outv_q[2];
	assign pos_x = outp_q[0];
	assign pos_y = outp_q[1];
	assign pos_z = outp_q[2];

endmodule

### src/ivpd_checker.sv
// ----------------------------------------------------------------------------
// ivpd_checker
// Port-level checks on the drift filter, bound to the top level.
// ----------------------------------------------------------------------------
module ivpd_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [ivpd_pkg::OUT_W-1:0]     vel_x,
	input logic signed [ivpd_pkg::OUT_W-1:0]     vel_y,
	input logic signed [ivpd_pkg::OUT_W-1:0]     vel_z,
	input logic signed [ivpd_pkg::OUT_W-1:0]     pos_x,
	input logic signed [ivpd_pkg::OUT_W-1:0]     pos_y,
	input logic signed [ivpd_pkg::OUT_W-1:0]     pos_z
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vel_x) && $stable(vel_y)
			&& $stable(vel_z) && $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
		else $error("result word changed while stalled");

	// result valid only drops when the word was taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result word dropped");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while busy");

	// the result cannot show up right after its accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind imu_velocity_position_drift_filter_core ivpd_checker u_ivpd_checker (.*);

### test/imu_velocity_position_drift_filter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_velocity_position_drift_filter_core_tb
// Self-checking bench for the three-axis velocity/position drift filter.
// A directed table covers the field extremes, every register and the
// degenerate gains. Long random runs follow under four idling patterns.
// Each accepted acceleration word runs through a fixed-point model held
// here, and every result word is compared field by field with the oldest
// expected word.
// ----------------------------------------------------------------------------
module imu_velocity_position_drift_filter_core_tb;

	// spare register index, writes to it must be dropped
	localparam logic [ivpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// wide enough for a 48-bit state times a 24-bit factor plus headroom
	typedef logic signed [79:0] wide_t;
	typedef logic signed [ivpd_pkg::STATE_W-1:0] state_t;
	typedef logic [ivpd_pkg::ACCEL_W-1:0] accel_t;
	typedef logic [ivpd_pkg::CFG_DAT_W-1:0] cfg_word_t;
	// one result word: [0..2] velocity x/y/z, [3..5] position x/y/z
	typedef logic [2*ivpd_pkg::AXES-1:0][ivpd_pkg::OUT_W-1:0] motion_t;
	typedef accel_t [ivpd_pkg::AXES-1:0] accel_vec_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [ivpd_pkg::CFG_IDX_W-1:0] idx;
		cfg_word_t                     data;
		accel_t                        ax;
		accel_t                        ay;
		accel_t                        az;
		bit                            zero_out;	// expected word is all zero, no model needed
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [ivpd_pkg::ACCEL_W-1:0] accel_x;
	logic signed [ivpd_pkg::ACCEL_W-1:0] accel_y;
	logic signed [ivpd_pkg::ACCEL_W-1:0] accel_z;
	logic out_valid;
	logic out_stall;
	logic signed [ivpd_pkg::OUT_W-1:0] vel_x;
	logic signed [ivpd_pkg::OUT_W-1:0] vel_y;
	logic signed [ivpd_pkg::OUT_W-1:0] vel_z;
	logic signed [ivpd_pkg::OUT_W-1:0] pos_x;
	logic signed [ivpd_pkg::OUT_W-1:0] pos_y;
	logic signed [ivpd_pkg::OUT_W-1:0] pos_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [ivpd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ivpd_pkg::CFG_DAT_W-1:0] cfg_data;

	// filter model: register copies and per-axis integrator states
	logic [ivpd_pkg::DT_W-1:0]   cur_dt;
	logic [ivpd_pkg::GAIN_W-1:0] cur_k;
	logic [ivpd_pkg::GAIN_W-1:0] cur_og;
	state_t                      vel_acc [ivpd_pkg::AXES];
	state_t                      pos_acc [ivpd_pkg::AXES];

	motion_t  motion_q [$];	// expected result words, oldest first
	dir_row_t dir_tab [$];
	int       mismatch_count;
	int       send_idle_pct;	// chance per cycle that the sender holds off
	int       stall_pct;	// chance per cycle that the receiver stalls

	imu_velocity_position_drift_filter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// ---- directed table rows ----

	function automatic void add_reg(input logic [ivpd_pkg::CFG_IDX_W-1:0] idx,
			input cfg_word_t data);
		dir_row_t row;
		row = '{ROW_REG, idx, data, '0, '0, '0, 1'b0};
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	function automatic void add_word(input accel_t ax, input accel_t ay, input accel_t az,
			input bit zero_out);
		dir_row_t row;
		row = '{ROW_WORD, REG_SPARE, '0, ax, ay, az, zero_out};
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	// ---- fixed-point model ----

	function automatic state_t clamp48(input wide_t v);
		wide_t top;
		top = (wide_t'(1) <<< (ivpd_pkg::STATE_W - 1)) - 1;
		if (v > top)
			return state_t'(top);
		if (v < -top - 1)
			return state_t'(-top - 1);
		return state_t'(v);
	endfunction

	// y = round(sat48(sum) * k / 2^16), round half up
	function automatic state_t hp_filter(input wide_t sum);
		wide_t t;
		t = wide_t'(clamp48(sum)) * wide_t'(cur_k) + 32768;
		return state_t'(t >>> 16);
	endfunction

	// round(state * og / 2^32), clamped to 32 bits
	function automatic logic [ivpd_pkg::OUT_W-1:0] scale_out(input state_t s);
		wide_t t;
		t = (wide_t'(s) * wide_t'(cur_og) + (wide_t'(1) <<< 31)) >>> 32;
		if (t > wide_t'(32'sh7FFFFFFF))
			return 32'h7FFFFFFF;
		if (t < -wide_t'(32'sh7FFFFFFF) - 1)
			return 32'h80000000;
		return t[ivpd_pkg::OUT_W-1:0];
	endfunction

	// one sample: integrate into velocity, filter, integrate into position, filter
	function automatic motion_t advance_motion(input accel_vec_t a);
		motion_t m;
		wide_t   inc;
		wide_t   pinc;
		for (int i = 0; i < ivpd_pkg::AXES; i++) begin
			// Q7.16 * Q0.24 -> Q.40, down to Q.32
			inc = (wide_t'($signed(a[i])) * wide_t'(cur_dt) + 128) >>> 8;
			vel_acc[i] = hp_filter(wide_t'(vel_acc[i]) + inc);
			// Q.32 * Q0.24 -> Q.56, down to Q.32
			pinc = (wide_t'(vel_acc[i]) * wide_t'(cur_dt) + (wide_t'(1) <<< 23)) >>> 24;
			pos_acc[i] = hp_filter(wide_t'(pos_acc[i]) + pinc);
			m[i] = scale_out(vel_acc[i]);
			m[ivpd_pkg::AXES + i] = scale_out(pos_acc[i]);
		end
		return m;
	endfunction

	function automatic void apply_reg(input logic [ivpd_pkg::CFG_IDX_W-1:0] idx,
			input cfg_word_t data);
		case (idx)
			ivpd_pkg::REG_SAMPLE_PERIOD: cur_dt = data[ivpd_pkg::DT_W-1:0];
			ivpd_pkg::REG_HP_GAIN:       cur_k  = data[ivpd_pkg::GAIN_W-1:0];
			ivpd_pkg::REG_OUTPUT_GAIN:   cur_og = data[ivpd_pkg::GAIN_W-1:0];
			default: ;	// spare index: dropped
		endcase
	endfunction

	// ---- drivers ----

	// Register write, only once every pending result word is out. Each item
	// yields exactly one word, so an empty queue means the core is idle.
	task automatic write_reg(input logic [ivpd_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
		while (motion_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Present one acceleration word, hold it until taken, then log the
	// expected result. Valid drops at the negedge after the accept, so the
	// next call never touches in_valid twice in one step.
	task automatic send_word(input accel_vec_t a, input bit zero_out);
		motion_t m;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid <= 1'b1;
		accel_x  <= a[0];
		accel_y  <= a[1];
		accel_z  <= a[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		m = advance_motion(a);
		if (zero_out)
			motion_q.insert(motion_q.size(), '0);
		else
			motion_q.insert(motion_q.size(), m);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// One random phase with its own register set and idling pattern.
	// push_hard keeps x near +full scale and y near -full scale, so both
	// integrators run into the 48-bit clamp after ~260 words at k close to 1.
	task automatic run_phase(input int idle_pct, input int hold_pct, input int words,
			input cfg_word_t dt, input cfg_word_t k, input cfg_word_t og,
			input bit push_hard);
		accel_vec_t a;
		write_reg(ivpd_pkg::REG_SAMPLE_PERIOD, dt);
		write_reg(ivpd_pkg::REG_HP_GAIN, k);
		write_reg(ivpd_pkg::REG_OUTPUT_GAIN, og);
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
		repeat (words) begin
			if (push_hard) begin
				a[0] = accel_t'(24'h7FFFFF - $urandom_range(0, 4095));
				a[1] = accel_t'(24'h800000 + $urandom_range(0, 4095));
				a[2] = accel_t'($urandom);
			end else begin
				// mostly full-range noise, now and then a rail value
				for (int i = 0; i < ivpd_pkg::AXES; i++)
					if ($urandom_range(0, 15) == 0)
						a[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
					else
						a[i] = accel_t'($urandom);
			end
			send_word(a, 1'b0);
		end
	endtask

	// ---- receiver ----

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result check, sampled at the rising edge before the core updates
	always @(posedge clk) begin : take_motion
		motion_t seen;
		motion_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {pos_z, pos_y, pos_x, vel_z, vel_y, vel_x};
			if (motion_q.size() == 0) begin
				note_mismatch("result word with nothing expected");
			end else begin
				want = motion_q.pop_front();
				for (int i = 0; i < 2*ivpd_pkg::AXES; i++)
					if (seen[i] !== want[i])
						note_mismatch($sformatf("%s_%c got %0d expected %0d",
							(i < ivpd_pkg::AXES) ? "vel" : "pos",
							8'd120 + i % ivpd_pkg::AXES,
							$signed(seen[i]), $signed(want[i])));
			end
		end
	end

	// ---- stimulus ----

	initial begin : stimulus
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		accel_x   = '0;
		accel_y   = '0;
		accel_z   = '0;
		cfg_valid = 1'b0;
		cfg_index = ivpd_pkg::REG_SAMPLE_PERIOD;
		cfg_data  = '0;
		cur_dt    = ivpd_pkg::DT_RESET;
		cur_k     = ivpd_pkg::K_RESET;
		cur_og    = ivpd_pkg::OG_RESET;
		for (int i = 0; i < ivpd_pkg::AXES; i++) begin
			vel_acc[i] = '0;
			pos_acc[i] = '0;
		end
		mismatch_count = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;

		// directed table
		//       ax          ay          az          zero
		// from reset with a zero sample the states stay at zero
		add_word(24'h000000, 24'h000000, 24'h000000, 1'b1);
		// rails at the default registers
		add_word(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
		add_word(24'h800000, 24'h7FFFFF, 24'h000001, 1'b0);
		add_word(24'h000001, 24'hFFFFFF, 24'h800000, 1'b0);
		// longest step, k just below one, largest scale: position heads for the clamp
		add_reg(ivpd_pkg::REG_SAMPLE_PERIOD, 24'hFFFFFF);
		add_reg(ivpd_pkg::REG_HP_GAIN,       24'h00FFFF);
		add_reg(ivpd_pkg::REG_OUTPUT_GAIN,   24'hFFFFFF);
		add_word(24'h7FFFFF, 24'h800000, 24'h555555, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'hAAAAAA, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'h555555, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'hAAAAAA, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'h555555, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'hAAAAAA, 1'b0);
		// zero output gain: outputs zero while the states keep moving
		add_reg(ivpd_pkg::REG_OUTPUT_GAIN,   24'h000000);
		add_word(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		add_reg(ivpd_pkg::REG_OUTPUT_GAIN,   24'h000001);
		add_word(24'h800000, 24'h800000, 24'h800000, 1'b0);
		// zero step: no integration, the states only decay
		add_reg(ivpd_pkg::REG_SAMPLE_PERIOD, 24'h000000);
		add_word(24'h7FFFFF, 24'h800000, 24'h123456, 1'b0);
		add_word(24'h7FFFFF, 24'h800000, 24'hEDCBA9, 1'b0);
		add_reg(ivpd_pkg::REG_SAMPLE_PERIOD, 24'h000001);
		add_word(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
		// zero k wipes both states, so everything reads zero
		add_reg(ivpd_pkg::REG_HP_GAIN,       24'h000000);
		add_reg(ivpd_pkg::REG_OUTPUT_GAIN,   24'h00FFFF);
		add_word(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
		add_reg(ivpd_pkg::REG_HP_GAIN,       24'h000001);
		add_word(24'h7FFFFF, 24'h800000, 24'h400000, 1'b0);
		// spare index must change nothing
		add_reg(REG_SPARE,                   24'hFFFFFF);
		add_word(24'hC00000, 24'h3FFFFF, 24'h000000, 1'b0);
		// back to the reset values
		add_reg(ivpd_pkg::REG_SAMPLE_PERIOD, 24'h010000);
		add_reg(ivpd_pkg::REG_HP_GAIN,       24'h00FF60);
		add_reg(ivpd_pkg::REG_OUTPUT_GAIN,   24'h0003E8);
		add_word(24'h0A0000, 24'hF60000, 24'h09CCCC, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[r])
			if (dir_tab[r].kind == ROW_REG)
				write_reg(dir_tab[r].idx, dir_tab[r].data);
			else
				send_word({dir_tab[r].az, dir_tab[r].ay, dir_tab[r].ax}, dir_tab[r].zero_out);

		// back to back, max step and k just below one: drive into the clamps
		run_phase(0, 0, 300, 24'hFFFFFF, 24'h00FFFF,
			cfg_word_t'($urandom_range(1, 65535)), 1'b1);
		// sender mostly idle, random step, slow-ish filter
		run_phase(86, 0, 40, cfg_word_t'($urandom), cfg_word_t'($urandom_range(60000, 65535)),
			cfg_word_t'($urandom), 1'b0);
		// receiver mostly stalled, reset registers
		run_phase(0, 86, 40, cfg_word_t'(ivpd_pkg::DT_RESET), cfg_word_t'(ivpd_pkg::K_RESET),
			cfg_word_t'(ivpd_pkg::OG_RESET), 1'b0);
		// light idling on both sides, registers anywhere in range
		run_phase(6, 6, 40, cfg_word_t'($urandom), cfg_word_t'($urandom),
			cfg_word_t'($urandom), 1'b0);

		@(negedge clk);
		send_idle_pct = 0;
		// drain, then leave room for a stray word
		while (motion_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
